// ===== hw/rtl/gis_pkg.sv =====
// Shared types and constants of the recursive Gaussian smoother.
`default_nettype none

package gis_pkg;

   // Data widths
   localparam int STORE_W  = 40;   // signed Q24.16 working value
   localparam int SAMPLE_W = 32;   // signed Q16.16 stream sample
   localparam int FACTOR_W = 24;   // widest unsigned coefficient
   localparam int NU_W     = 16;   // pole coefficient, Q0.16
   localparam int COUNT_W  = 4;    // pass counter
   localparam int STATUS_W = 2;

   // Multiplier split: magnitude is taken in two halves
   localparam int HALF_W = STORE_W / 2;
   localparam int PROD_W = HALF_W + FACTOR_W;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [STORE_W-1:0] store_word_type;

   typedef enum logic [1:0] {
      CSR_POLE_COEF  = 2'd0,
      CSR_EDGE_SCALE = 2'd1,
      CSR_PASS_SCALE = 2'd2,
      CSR_PASS_COUNT = 2'd3
   } csr_index_type;

   localparam logic [NU_W-1:0]     POLE_COEF_RESET  = 16'd32768;
   localparam logic [FACTOR_W-1:0] EDGE_SCALE_RESET = 24'd131072;
   localparam logic [FACTOR_W-1:0] PASS_SCALE_RESET = 24'd4194304;
   localparam logic [COUNT_W-1:0]  PASS_COUNT_RESET = 4'd4;

   // Request kinds carried on tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DROPPED = 2'd2
   } read_status_type;

   // Rounding shift of the shared multiplier
   typedef enum logic {
      SHIFT_Q16 = 1'b0,
      SHIFT_Q24 = 1'b1
   } shift_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LOW,
      MUL_HIGH,
      MUL_ROUND
   } mul_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_OUT,
      ST_HEAD_RD,
      ST_HEAD_MUL,
      ST_HEAD_WAIT,
      ST_FWD_MUL,
      ST_FWD_WAIT,
      ST_TAIL_MUL,
      ST_TAIL_WAIT,
      ST_BWD_MUL,
      ST_BWD_WAIT,
      ST_SCL_RD,
      ST_SCL_MUL,
      ST_SCL_WAIT
   } seq_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gis_mul_round.sv =====
// Shared multiplier: signed 40-bit value times unsigned factor, rounded and saturated.
`default_nettype none

module gis_mul_round (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire gis_pkg::store_word_type   operand,
   input  wire logic [gis_pkg::FACTOR_W-1:0] factor,
   input  wire gis_pkg::shift_type        shift_sel,
   output logic                           done,
   output gis_pkg::store_word_type        result
);
   import gis_pkg::*;

   localparam int FULL_W = 2 * HALF_W + FACTOR_W;

   localparam logic [FULL_W:0]    ROUND_Q16 = (FULL_W + 1)'(1) << 15;
   localparam logic [FULL_W:0]    ROUND_Q24 = (FULL_W + 1)'(1) << 23;
   localparam logic [FULL_W:0]    LIMIT_NEG = (FULL_W + 1)'(1) << (STORE_W - 1);
   localparam logic [FULL_W:0]    LIMIT_POS = LIMIT_NEG - (FULL_W + 1)'(1);

   mul_phase_type             phase_ff, phase_in;
   logic                      neg_ff, neg_in;
   logic [STORE_W-1:0]        mag_ff, mag_in;
   logic [FACTOR_W-1:0]       factor_ff, factor_in;
   shift_type                 shift_ff, shift_in;
   logic [PROD_W-1:0]         lo_ff, lo_in;
   logic [PROD_W-1:0]         hi_ff, hi_in;
   logic                      done_ff, done_in;
   store_word_type            result_ff, result_in;

   logic [HALF_W-1:0]         mul_a;
   logic [PROD_W-1:0]         prod;
   logic [FULL_W:0]           full_sum;
   logic [FULL_W:0]           shifted;
   logic [FULL_W:0]           limit;
   logic [STORE_W-1:0]        mag_res;

   // Sequence the partial products
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         MUL_IDLE:  if (start) phase_in = MUL_LOW;
         MUL_LOW:   phase_in = MUL_HIGH;
         MUL_HIGH:  phase_in = MUL_ROUND;
         MUL_ROUND: phase_in = MUL_IDLE;
         default:   phase_in = MUL_IDLE;
      endcase
   end

   // One half-width multiplier, shared by both halves
   assign mul_a = (phase_ff == MUL_HIGH) ? mag_ff[STORE_W-1:HALF_W] : mag_ff[HALF_W-1:0];
   assign prod  = mul_a * factor_ff;

   // Combine halves, round half away from zero, clamp the magnitude
   always_comb begin
      full_sum = (FULL_W + 1)'(lo_ff) + ((FULL_W + 1)'(hi_ff) << HALF_W)
               + ((shift_ff == SHIFT_Q24) ? ROUND_Q24 : ROUND_Q16);
      shifted  = (shift_ff == SHIFT_Q24) ? (full_sum >> 24) : (full_sum >> 16);
      limit    = neg_ff ? LIMIT_NEG : LIMIT_POS;
      mag_res  = (shifted > limit) ? limit[STORE_W-1:0] : shifted[STORE_W-1:0];
   end

   // Datapath next values
   always_comb begin
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      factor_in = factor_ff;
      shift_in  = shift_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (phase_ff)
         MUL_IDLE: begin
            if (start) begin
               neg_in    = operand[STORE_W-1];
               mag_in    = operand[STORE_W-1] ? STORE_W'(-operand) : STORE_W'(operand);
               factor_in = factor;
               shift_in  = shift_sel;
            end
         end
         MUL_LOW:   lo_in = prod;
         MUL_HIGH:  hi_in = prod;
         MUL_ROUND: begin
            result_in = neg_ff ? store_word_type'(-mag_res) : store_word_type'(mag_res);
            done_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      factor_ff <= factor_in;
      shift_ff  <= shift_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_iir_smoother_unit.sv =====
// Top level of the recursive Gaussian smoother: stream ports, register file, store, sequencer.
`default_nettype none

// Samples are loaded one transfer at a time (tuser 0) into an internal store of
// MAX_SAMPLES entries; the load carrying tlast closes the block and, if pass_count
// is not zero, starts the filter passes, during which req_tready stays low. A load
// is written straight into the store while there is room; a read (tuser 1) goes
// through the registered store read port into the output register. All arithmetic
// goes through one shared multiplier that forms each product from a low and a high
// half product and then rounds; each pass runs a causal and an anti-causal sweep
// and then a gain sweep, and closing a block runs pass_count passes. Reads return
// the smoothed samples in order with tlast on the last one and a status on tuser.
module gaussian_iir_smoother_unit #(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [gis_pkg::SAMPLE_W-1:0]  req_tdata,   // [31:0] sample_in
   input  wire logic                          req_tuser,   // [0] func
   input  wire logic                          req_tlast,   // end_of_block
   // Result stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [gis_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [31:0] sample_out
   output logic [gis_pkg::STATUS_W-1:0]       rsp_tuser,   // [1:0] read_status
   output logic                               rsp_tlast,   // final_sample
   // Configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [gis_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [gis_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gis_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import gis_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int LW = $clog2(MAX_SAMPLES + 1);
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_SAMPLES);

   localparam logic signed [STORE_W-1:0] OUT_MAX = STORE_W'(64'sd2147483647);
   localparam logic signed [STORE_W-1:0] OUT_MIN = -STORE_W'(64'sd2147483648);

   // Configuration registers
   logic [NU_W-1:0]      pole_coef_ff;
   logic [FACTOR_W-1:0]  edge_scale_ff;
   logic [FACTOR_W-1:0]  pass_scale_ff;
   logic [COUNT_W-1:0]   pass_count_ff;
   logic                 csr_write;
   csr_index_type        csr_index;

   // Sequencer and block state
   seq_state_type        state_ff, state_in;
   logic [LW-1:0]        blen_ff, blen_in;
   logic [LW-1:0]        rpos_ff, rpos_in;
   logic                 ready_ff, ready_in;
   logic                 dropped_ff, dropped_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [COUNT_W-1:0]   pass_ff, pass_in;
   store_word_type       prev_ff, prev_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   read_status_type      rsp_status_ff, rsp_status_in;

   // Sample store
   store_word_type       store_mem [MAX_SAMPLES];
   store_word_type       mem_rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   store_word_type       mem_wdata;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;

   // Shared multiplier hookup
   logic                 mul_start;
   store_word_type       mul_operand;
   logic [FACTOR_W-1:0]  mul_factor;
   shift_type            mul_shift;
   logic                 mul_done;
   store_word_type       mul_result;

   // Helpers
   logic                 req_xfer;
   logic [LW-1:0]        load_base;
   logic [AW-1:0]        last_idx;
   logic [STORE_W:0]     acc_wide;
   store_word_type       acc_sat;
   logic                 last_pass;
   logic                 read_empty;
   logic                 read_fin;
   logic [SAMPLE_W-1:0]  read_sat;

   gis_mul_round u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand   (mul_operand),
      .factor    (mul_factor),
      .shift_sel (mul_shift),
      .done      (mul_done),
      .result    (mul_result)
   );

   // Register file access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         CSR_POLE_COEF:  csr_prdata = CSR_DATA_W'(pole_coef_ff);
         CSR_EDGE_SCALE: csr_prdata = CSR_DATA_W'(edge_scale_ff);
         CSR_PASS_SCALE: csr_prdata = CSR_DATA_W'(pass_scale_ff);
         CSR_PASS_COUNT: csr_prdata = CSR_DATA_W'(pass_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_coef_ff  <= POLE_COEF_RESET;
         edge_scale_ff <= EDGE_SCALE_RESET;
         pass_scale_ff <= PASS_SCALE_RESET;
         pass_count_ff <= PASS_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POLE_COEF:  pole_coef_ff  <= csr_pwdata[NU_W-1:0];
            CSR_EDGE_SCALE: edge_scale_ff <= csr_pwdata[FACTOR_W-1:0];
            CSR_PASS_SCALE: pass_scale_ff <= csr_pwdata[FACTOR_W-1:0];
            CSR_PASS_COUNT: pass_count_ff <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake and shared helpers
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign load_base  = ready_ff ? '0 : blen_ff;
   assign last_idx   = AW'(blen_ff - LW'(1));
   assign last_pass  = (COUNT_W'(pass_ff + COUNT_W'(1)) == pass_count_ff);

   // Add product to stored sample, saturate to the store width
   always_comb begin
      acc_wide = {mem_rdata_ff[STORE_W-1], mem_rdata_ff} + {mul_result[STORE_W-1], mul_result};
      if (acc_wide[STORE_W] != acc_wide[STORE_W-1]) begin
         acc_sat = acc_wide[STORE_W] ? {1'b1, {(STORE_W-1){1'b0}}} : {1'b0, {(STORE_W-1){1'b1}}};
      end else begin
         acc_sat = acc_wide[STORE_W-1:0];
      end
   end

   // Saturate a stored value to the stream sample width
   always_comb begin
      if (mem_rdata_ff > OUT_MAX) begin
         read_sat = OUT_MAX[SAMPLE_W-1:0];
      end else if (mem_rdata_ff < OUT_MIN) begin
         read_sat = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         read_sat = mem_rdata_ff[SAMPLE_W-1:0];
      end
   end

   assign read_empty = !ready_ff || (rpos_ff >= blen_ff);
   assign read_fin   = (LW'(rpos_ff + LW'(1)) == blen_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == FUNC_READ) begin
                  state_in = ST_READ_OUT;
               end else if (req_tlast && (pass_count_ff != '0)) begin
                  state_in = ST_HEAD_RD;
               end
            end
         end
         ST_READ_OUT:  state_in = ST_IDLE;
         ST_HEAD_RD:   state_in = ST_HEAD_MUL;
         ST_HEAD_MUL:  state_in = ST_HEAD_WAIT;
         ST_HEAD_WAIT: begin
            if (mul_done) state_in = (last_idx == '0) ? ST_TAIL_MUL : ST_FWD_MUL;
         end
         ST_FWD_MUL:   state_in = ST_FWD_WAIT;
         ST_FWD_WAIT: begin
            if (mul_done) state_in = (idx_ff == last_idx) ? ST_TAIL_MUL : ST_FWD_MUL;
         end
         ST_TAIL_MUL:  state_in = ST_TAIL_WAIT;
         ST_TAIL_WAIT: begin
            if (mul_done) state_in = (last_idx == '0) ? ST_SCL_RD : ST_BWD_MUL;
         end
         ST_BWD_MUL:   state_in = ST_BWD_WAIT;
         ST_BWD_WAIT: begin
            if (mul_done) state_in = (idx_ff == '0) ? ST_SCL_RD : ST_BWD_MUL;
         end
         ST_SCL_RD:    state_in = ST_SCL_MUL;
         ST_SCL_MUL:   state_in = ST_SCL_WAIT;
         ST_SCL_WAIT: begin
            if (mul_done && (idx_ff == last_idx)) begin
               state_in = last_pass ? ST_IDLE : ST_HEAD_RD;
            end else if (mul_done) begin
               state_in = ST_SCL_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, store access and multiplier control
   always_comb begin
      blen_in       = blen_ff;
      rpos_in       = rpos_ff;
      ready_in      = ready_ff;
      dropped_in    = dropped_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      mul_start     = 1'b0;
      mul_operand   = prev_ff;
      mul_factor    = FACTOR_W'(pole_coef_ff);
      mul_shift     = SHIFT_Q16;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_tuser == FUNC_LOAD)) begin
               // A load after finished results starts a fresh block
               ready_in   = 1'b0;
               dropped_in = ready_ff ? 1'b0 : dropped_ff;
               if (load_base < LEN_MAX) begin
                  mem_we    = 1'b1;
                  mem_waddr = load_base[AW-1:0];
                  mem_wdata = STORE_W'(signed'(req_tdata));
                  blen_in   = LW'(load_base + LW'(1));
               end else begin
                  blen_in    = load_base;
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  rpos_in  = '0;
                  pass_in  = '0;
                  idx_in   = '0;
                  ready_in = (pass_count_ff == '0);
               end
            end else if (req_xfer) begin
               mem_re    = 1'b1;
               mem_raddr = rpos_ff[AW-1:0];
            end
         end
         ST_READ_OUT: begin
            rsp_valid_in = 1'b1;
            if (read_empty) begin
               rsp_data_in   = '0;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_data_in   = read_sat;
               rsp_last_in   = read_fin;
               rsp_status_in = dropped_ff ? STATUS_DROPPED : STATUS_OK;
               if (read_fin) begin
                  blen_in    = '0;
                  rpos_in    = '0;
                  ready_in   = 1'b0;
                  dropped_in = 1'b0;
               end else begin
                  rpos_in = LW'(rpos_ff + LW'(1));
               end
            end
         end
         ST_HEAD_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end
         ST_HEAD_MUL: begin
            mul_start   = 1'b1;
            mul_operand = mem_rdata_ff;
            mul_factor  = edge_scale_ff;
         end
         ST_HEAD_WAIT: begin
            if (mul_done) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = mul_result;
               prev_in   = mul_result;
               idx_in    = (last_idx == '0) ? '0 : AW'(1);
            end
         end
         ST_FWD_MUL, ST_BWD_MUL: begin
            // Fetch the target sample while the product of its neighbor runs
            mem_re    = 1'b1;
            mem_raddr = idx_ff;
            mul_start = 1'b1;
         end
         ST_FWD_WAIT: begin
            if (mul_done) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = acc_sat;
               prev_in   = acc_sat;
               if (idx_ff != last_idx) idx_in = AW'(idx_ff + AW'(1));
            end
         end
         ST_TAIL_MUL: begin
            mul_start  = 1'b1;
            mul_factor = edge_scale_ff;
         end
         ST_TAIL_WAIT: begin
            if (mul_done) begin
               mem_we    = 1'b1;
               mem_waddr = last_idx;
               mem_wdata = mul_result;
               prev_in   = mul_result;
               idx_in    = (last_idx == '0) ? '0 : AW'(last_idx - AW'(1));
            end
         end
         ST_BWD_WAIT: begin
            if (mul_done) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = acc_sat;
               prev_in   = acc_sat;
               if (idx_ff != '0) idx_in = AW'(idx_ff - AW'(1));
            end
         end
         ST_SCL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = idx_ff;
         end
         ST_SCL_MUL: begin
            mul_start   = 1'b1;
            mul_operand = mem_rdata_ff;
            mul_factor  = pass_scale_ff;
            mul_shift   = SHIFT_Q24;
         end
         ST_SCL_WAIT: begin
            if (mul_done) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = mul_result;
               if (idx_ff == last_idx) begin
                  idx_in  = '0;
                  pass_in = COUNT_W'(pass_ff + COUNT_W'(1));
                  if (last_pass) ready_in = 1'b1;
               end else begin
                  idx_in = AW'(idx_ff + AW'(1));
               end
            end
         end
         default: ;
      endcase
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blen_ff      <= '0;
         rpos_ff      <= '0;
         ready_ff     <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         blen_ff      <= blen_in;
         rpos_ff      <= rpos_in;
         ready_ff     <= ready_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
      end
      prev_ff       <= prev_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Results only appear after a read lookup
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ_OUT))
      else $error("result raised outside a read");

   // Results are never marked ready while the passes still run
   a_no_ready_in_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_READ_OUT) |-> !ready_ff)
      else $error("results ready during filter passes");

   // Read pointer stays inside a finished block
   a_rpos_in_block: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (rpos_ff < blen_ff))
      else $error("read position beyond block");

   // Block length never exceeds the store
   a_blen_bound: assert property (@(posedge clock) disable iff (reset)
      blen_ff <= LEN_MAX)
      else $error("block length beyond store depth");

endmodule

`default_nettype wire
